@@ rtl/nearest_point_within_radius_macros.svh @@
// Assertion helpers used by the block's top-level RTL
`ifndef NEAREST_POINT_WITHIN_RADIUS_MACROS_SVH
`define NEAREST_POINT_WITHIN_RADIUS_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define NPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is held
`define NPR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/npr_pkg.sv @@
package npr_pkg;

    localparam int COORD_W = 24;
    localparam int READ_W  = 48;
    localparam int RAD_W   = 23;
    localparam int ABS_W   = 24;   // |a - b| of two 24-bit values stays below 2^24
    localparam int SQ_W    = 2 * ABS_W;
    localparam int D2_W    = SQ_W + 2;
    localparam int FUNC_W  = 2;

    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd1;
    localparam logic [FUNC_W-1:0] FN_QUERY = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN
    } t_state;

    // one table entry, also used as the write request
    typedef struct packed {
        logic                      valid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [READ_W-1:0]         reading;
    } t_point;

    typedef struct packed {
        logic              valid;
        logic [D2_W-1:0]   d2;
        logic [READ_W-1:0] reading;
    } t_dist_res;

endpackage

@@ rtl/npr_store.sv @@
module npr_store
    import npr_pkg::*;
#(
    parameter int MAX_POINTS = 1024,
    parameter int AW         = 10
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_point        i_wr,
    input  logic [AW-1:0] i_waddr,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_raddr,
    output t_point        o_pt
);

    logic signed [COORD_W-1:0] mem_x [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_y [MAX_POINTS];
    logic signed [COORD_W-1:0] mem_z [MAX_POINTS];
    logic [READ_W-1:0]         mem_r [MAX_POINTS];

    logic                      r_rd_valid;
    logic signed [COORD_W-1:0] r_rd_x;
    logic signed [COORD_W-1:0] r_rd_y;
    logic signed [COORD_W-1:0] r_rd_z;
    logic [READ_W-1:0]         r_rd_r;

    always_ff @(posedge i_clk) begin
        if (i_wr.valid) begin
            mem_x[i_waddr] <= i_wr.x;
            mem_y[i_waddr] <= i_wr.y;
            mem_z[i_waddr] <= i_wr.z;
            mem_r[i_waddr] <= i_wr.reading;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_x <= mem_x[i_raddr];
        r_rd_y <= mem_y[i_raddr];
        r_rd_z <= mem_z[i_raddr];
        r_rd_r <= mem_r[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_rd_en;
        end
    end

    assign o_pt.valid   = r_rd_valid;
    assign o_pt.x       = r_rd_x;
    assign o_pt.y       = r_rd_y;
    assign o_pt.z       = r_rd_z;
    assign o_pt.reading = r_rd_r;

endmodule

@@ rtl/npr_dist.sv @@
module npr_dist
    import npr_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic signed [COORD_W-1:0] i_qx,
    input  logic signed [COORD_W-1:0] i_qy,
    input  logic signed [COORD_W-1:0] i_qz,
    input  t_point                    i_pt,
    output t_dist_res                 o_res
);

    // stage 1: absolute differences
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] dz;
    logic [COORD_W:0]        mx;
    logic [COORD_W:0]        my;
    logic [COORD_W:0]        mz;

    logic              r_v1;
    logic [ABS_W-1:0]  r_ax;
    logic [ABS_W-1:0]  r_ay;
    logic [ABS_W-1:0]  r_az;
    logic [READ_W-1:0] r_rd1;

    // stage 2: squares
    logic              r_v2;
    logic [SQ_W-1:0]   r_sx;
    logic [SQ_W-1:0]   r_sy;
    logic [SQ_W-1:0]   r_sz;
    logic [READ_W-1:0] r_rd2;

    // stage 3: sum
    logic              r_v3;
    logic [D2_W-1:0]   r_d2;
    logic [READ_W-1:0] r_rd3;

    always_comb begin
        dx = $signed({i_qx[COORD_W-1], i_qx}) - $signed({i_pt.x[COORD_W-1], i_pt.x});
        dy = $signed({i_qy[COORD_W-1], i_qy}) - $signed({i_pt.y[COORD_W-1], i_pt.y});
        dz = $signed({i_qz[COORD_W-1], i_qz}) - $signed({i_pt.z[COORD_W-1], i_pt.z});
        mx = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
        my = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
        mz = dz[COORD_W] ? (COORD_W+1)'(-dz) : (COORD_W+1)'(dz);
    end

    always_ff @(posedge i_clk) begin
        r_ax  <= mx[ABS_W-1:0];
        r_ay  <= my[ABS_W-1:0];
        r_az  <= mz[ABS_W-1:0];
        r_rd1 <= i_pt.reading;
        r_sx  <= r_ax * r_ax;
        r_sy  <= r_ay * r_ay;
        r_sz  <= r_az * r_az;
        r_rd2 <= r_rd1;
        r_d2  <= D2_W'(r_sx) + D2_W'(r_sy) + D2_W'(r_sz);
        r_rd3 <= r_rd2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_pt.valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    assign o_res.valid   = r_v3;
    assign o_res.d2      = r_d2;
    assign o_res.reading = r_rd3;

endmodule

@@ rtl/nearest_point_within_radius.sv @@
// Nearest stored sample point within a radius. Items arrive on the s_axis
// side with the operation in tuser: load appends a point (dropped when the
// table holds MAX_POINTS), clear empties the table, query returns one word on
// m_axis with found in tuser and the three readings of the closest point whose
// squared distance is below search_radius squared (earliest point on a tie,
// zeros when none). A query walks the point memory one entry per cycle
// through the registered memory read into the distance pipeline (absolute
// differences, squares, sum), so the block stays busy in its scan and drain
// states until the result is registered; a new item is taken only once the
// output register is free or being drained. The user must write search_radius
// through i_cfg_we / i_cfg_wdata only while idle; this is not enforced.
`include "nearest_point_within_radius_macros.svh"

module nearest_point_within_radius
    import npr_pkg::*;
#(
    parameter int MAX_POINTS = 1024
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [RAD_W-1:0]    i_cfg_wdata,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    // tdata: pos_x[23:0], pos_y[47:24], pos_z[71:48], chemical_in[87:72],
    //        wind_speed_in[103:88], wind_direction_in[119:104]
    input  logic [119:0]        s_axis_tdata,
    // tuser: func[1:0]
    input  logic [FUNC_W-1:0]   s_axis_tuser,
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    // tdata: chemical_out[15:0], wind_speed_out[31:16], wind_direction_out[47:32]
    output logic [READ_W-1:0]   m_axis_tdata,
    // tuser: found[0]
    output logic                m_axis_tuser
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam logic [1:0] DRAIN_INIT = 2'd2;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    logic [CW-1:0]             r_addr, n_addr;
    logic [1:0]                r_drain, n_drain;
    logic [RAD_W-1:0]          r_rad;
    logic signed [COORD_W-1:0] r_qx, n_qx;
    logic signed [COORD_W-1:0] r_qy, n_qy;
    logic signed [COORD_W-1:0] r_qz, n_qz;
    logic [D2_W-1:0]           r_best, n_best;
    logic                      r_hit, n_hit;
    logic [READ_W-1:0]         r_reading, n_reading;
    logic                      r_out_valid, n_out_valid;
    logic                      r_out_found, n_out_found;
    logic [READ_W-1:0]         r_out_data, n_out_data;

    logic                      s_acc;
    logic                      rd_en;
    t_point                    wr;
    t_point                    pt;
    t_dist_res                 res;
    logic [2*RAD_W-1:0]        rad_sq;

    assign s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || m_axis_tready);
    assign s_acc         = s_axis_tvalid && s_axis_tready;
    assign rad_sq        = r_rad * r_rad;

    npr_store #(
        .MAX_POINTS (MAX_POINTS),
        .AW         (AW)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (wr),
        .i_waddr (r_count[AW-1:0]),
        .i_rd_en (rd_en),
        .i_raddr (r_addr[AW-1:0]),
        .o_pt    (pt)
    );

    npr_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qx    (r_qx),
        .i_qy    (r_qy),
        .i_qz    (r_qz),
        .i_pt    (pt),
        .o_res   (res)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_addr      = r_addr;
        n_drain     = r_drain;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_qz        = r_qz;
        n_best      = r_best;
        n_hit       = r_hit;
        n_reading   = r_reading;
        n_out_valid = r_out_valid && !m_axis_tready;
        n_out_found = r_out_found;
        n_out_data  = r_out_data;
        rd_en       = 1'b0;
        wr.valid    = 1'b0;
        wr.x        = s_axis_tdata[23:0];
        wr.y        = s_axis_tdata[47:24];
        wr.z        = s_axis_tdata[71:48];
        wr.reading  = s_axis_tdata[119:72];

        // strict less-than keeps the earliest point on a tie
        if (res.valid && (res.d2 < r_best)) begin
            n_best    = res.d2;
            n_hit     = 1'b1;
            n_reading = res.reading;
        end

        case (r_state)
            S_IDLE: begin
                if (s_acc) begin
                    case (s_axis_tuser)
                        FN_LOAD: begin
                            if (r_count < CW'(MAX_POINTS)) begin
                                wr.valid = 1'b1;
                                n_count  = r_count + 1'b1;
                            end
                        end
                        FN_CLEAR: begin
                            n_count = '0;
                        end
                        FN_QUERY: begin
                            n_qx      = s_axis_tdata[23:0];
                            n_qy      = s_axis_tdata[47:24];
                            n_qz      = s_axis_tdata[71:48];
                            n_addr    = '0;
                            n_best    = D2_W'(rad_sq);
                            n_hit     = 1'b0;
                            n_reading = '0;
                            n_state   = S_SCAN;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_addr < r_count) begin
                    rd_en  = 1'b1;
                    n_addr = r_addr + 1'b1;
                end else begin
                    n_drain = DRAIN_INIT;
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last point leaves the distance pipeline on the final count
                if (r_drain == 2'd0) begin
                    n_out_valid = 1'b1;
                    n_out_found = n_hit;
                    n_out_data  = n_reading;
                    n_state     = S_IDLE;
                end else begin
                    n_drain = r_drain - 1'b1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rad       <= RAD_W'(256);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) begin
                r_rad <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr      <= n_addr;
        r_drain     <= n_drain;
        r_qx        <= n_qx;
        r_qy        <= n_qy;
        r_qz        <= n_qz;
        r_best      <= n_best;
        r_hit       <= n_hit;
        r_reading   <= n_reading;
        r_out_found <= n_out_found;
        r_out_data  <= n_out_data;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_found;

    `NPR_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(MAX_POINTS),
                    "point count beyond table size")
    `NPR_ASSERT_NOW(a_res_in_query, i_clk, i_rst_n, res.valid,
                    (r_state == S_SCAN) || (r_state == S_DRAIN),
                    "distance result outside a query")
    `NPR_ASSERT_NOW(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_out_found,
                    r_out_data == '0, "miss word carries nonzero readings")
    `NPR_ASSERT_NXT(a_result_from_drain, i_clk, i_rst_n,
                    !r_out_valid && (r_state != S_DRAIN), !r_out_valid,
                    "result word without a finished query")

endmodule
